// File: src/oas_pkg.sv
// ----------------------------------------------------------------------------
// oas_pkg: shared types and constants for the obstacle avoidance sequencer
// Mode and motor codes, register indexes, reset values and the config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package oas_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;

  localparam int NOW_W   = 32;
  localparam int ECHO_W  = 15;
  localparam int POS_W   = 13;
  localparam int CMD_W   = 3;
  localparam int MODE_W  = 3;
  localparam int DIST_W  = 10;
  localparam int DUR_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Echo to distance: (echo * 1124) >> 16, about 0.0343 / 2 cm per us
  localparam int CM_SCALE_W = 11;
  localparam logic [CM_SCALE_W-1:0] CM_SCALE = CM_SCALE_W'(1124);
  localparam int CM_SHIFT = 16;
  localparam logic [ECHO_W-1:0] ECHO_MAX_US = ECHO_W'(30000);
  localparam logic [DIST_W-1:0] TIMEOUT_CM  = DIST_W'(500);

  // Register reset values
  localparam logic [DIST_W-1:0] OBSTACLE_CM_RST    = DIST_W'(20);
  localparam logic [DUR_W-1:0]  STOP_MS_RST        = DUR_W'(200);
  localparam logic [DUR_W-1:0]  RIGHT_TURN_MS_RST  = DUR_W'(400);
  localparam logic [DUR_W-1:0]  ADVANCE_MS_RST     = DUR_W'(500);
  localparam logic [DUR_W-1:0]  LEFT_TURN_MS_RST   = DUR_W'(400);
  localparam logic [DUR_W-1:0]  SEARCH_MS_RST      = DUR_W'(2000);
  localparam logic [POS_W-1:0]  LINE_LOW_RST       = POS_W'(500);
  localparam logic [POS_W-1:0]  LINE_HIGH_RST      = POS_W'(6500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBSTACLE_CM       = 4'd0,
    REG_STOP_MS           = 4'd1,
    REG_RIGHT_TURN_MS     = 4'd2,
    REG_ADVANCE_MS        = 4'd3,
    REG_LEFT_TURN_MS      = 4'd4,
    REG_SEARCH_TIMEOUT_MS = 4'd5,
    REG_LINE_LOW          = 4'd6,
    REG_LINE_HIGH         = 4'd7
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FOLLOW  = 3'd0,
    MODE_STOPPED = 3'd1,
    MODE_RIGHT   = 3'd2,
    MODE_ADVANCE = 3'd3,
    MODE_LEFT    = 3'd4,
    MODE_SEARCH  = 3'd5
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FOLLOW       = 3'd0,
    CMD_STOP         = 3'd1,
    CMD_SPIN_RIGHT   = 3'd2,
    CMD_FORWARD      = 3'd3,
    CMD_SPIN_LEFT    = 3'd4,
    CMD_FORWARD_LEFT = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] obstacle_cm;
    logic [DUR_W-1:0]  stop_ms;
    logic [DUR_W-1:0]  right_turn_ms;
    logic [DUR_W-1:0]  advance_ms;
    logic [DUR_W-1:0]  left_turn_ms;
    logic [DUR_W-1:0]  search_timeout_ms;
    logic [POS_W-1:0]  line_low;
    logic [POS_W-1:0]  line_high;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    mode_t             mode;
    logic [DIST_W-1:0] dist_cm;
    logic              load_start;
  } step_t;

endpackage

`default_nettype wire

// File: src/oas_step.sv
// ----------------------------------------------------------------------------
// oas_step: one control tick of the maneuver sequencer
// Computes motor command, next mode, distance and the mode-start reload.
// ----------------------------------------------------------------------------
`default_nettype none

module oas_step #(
  parameter int TIME_WIDTH = oas_pkg::TIME_WIDTH_DEFAULT
) (
  input  wire logic [oas_pkg::MODE_W-1:0] cur_mode,
  input  wire logic [TIME_WIDTH-1:0]      mode_start,
  input  wire oas_pkg::cfg_t              cfg,
  input  wire logic [oas_pkg::NOW_W-1:0]  now_ms,
  input  wire logic [oas_pkg::ECHO_W-1:0] echo_us,
  input  wire logic [oas_pkg::POS_W-1:0]  line_pos,
  output oas_pkg::step_t                  res
);

  localparam int PROD_W = oas_pkg::ECHO_W + oas_pkg::CM_SCALE_W;

  logic [TIME_WIDTH-1:0]         now_t;
  logic [TIME_WIDTH-1:0]         elapsed;
  logic [PROD_W-1:0]             prod;
  logic [oas_pkg::DIST_W-1:0]    dist_raw;
  logic                          line_found;

  // Timestamp reduced or extended to the time width, elapsed with wrap
  assign now_t   = TIME_WIDTH'(now_ms);
  assign elapsed = now_t - mode_start;

  assign prod = PROD_W'(echo_us) * PROD_W'(oas_pkg::CM_SCALE);

  always_comb begin
    if (echo_us == '0 || echo_us > oas_pkg::ECHO_MAX_US) begin
      dist_raw = oas_pkg::TIMEOUT_CM;
    end else begin
      dist_raw = prod[oas_pkg::CM_SHIFT +: oas_pkg::DIST_W];
    end
  end

  assign line_found = (line_pos > cfg.line_low) && (line_pos < cfg.line_high);

  always_comb begin
    res.cmd        = oas_pkg::CMD_FOLLOW;
    res.mode       = oas_pkg::MODE_FOLLOW;
    res.dist_cm    = '0;
    res.load_start = 1'b0;
    unique case (cur_mode)
      oas_pkg::MODE_STOPPED: begin
        res.cmd  = oas_pkg::CMD_STOP;
        res.mode = oas_pkg::MODE_STOPPED;
        if (elapsed >= TIME_WIDTH'(cfg.stop_ms)) begin
          res.mode       = oas_pkg::MODE_RIGHT;
          res.load_start = 1'b1;
        end
      end
      oas_pkg::MODE_RIGHT: begin
        res.cmd  = oas_pkg::CMD_SPIN_RIGHT;
        res.mode = oas_pkg::MODE_RIGHT;
        if (elapsed >= TIME_WIDTH'(cfg.right_turn_ms)) begin
          res.mode       = oas_pkg::MODE_ADVANCE;
          res.load_start = 1'b1;
        end
      end
      oas_pkg::MODE_ADVANCE: begin
        res.cmd  = oas_pkg::CMD_FORWARD;
        res.mode = oas_pkg::MODE_ADVANCE;
        if (elapsed >= TIME_WIDTH'(cfg.advance_ms)) begin
          res.mode       = oas_pkg::MODE_LEFT;
          res.load_start = 1'b1;
        end
      end
      oas_pkg::MODE_LEFT: begin
        res.cmd  = oas_pkg::CMD_SPIN_LEFT;
        res.mode = oas_pkg::MODE_LEFT;
        if (elapsed >= TIME_WIDTH'(cfg.left_turn_ms)) begin
          res.mode       = oas_pkg::MODE_SEARCH;
          res.load_start = 1'b1;
        end
      end
      oas_pkg::MODE_SEARCH: begin
        res.cmd  = oas_pkg::CMD_FORWARD_LEFT;
        res.mode = oas_pkg::MODE_SEARCH;
        // Line found wins over timeout; keep the start time on return
        if (line_found) begin
          res.mode = oas_pkg::MODE_FOLLOW;
        end else if (elapsed >= TIME_WIDTH'(cfg.search_timeout_ms)) begin
          res.mode       = oas_pkg::MODE_LEFT;
          res.load_start = 1'b1;
        end
      end
      default: begin
        // Follow mode, and the two unused codes behave the same
        res.dist_cm = dist_raw;
        if (dist_raw <= cfg.obstacle_cm) begin
          res.cmd        = oas_pkg::CMD_STOP;
          res.mode       = oas_pkg::MODE_STOPPED;
          res.load_start = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/obstacle_avoid_sequencer.sv
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer: line-follow car obstacle maneuver sequencer
// One control tick in, one motor command out, with a timed avoid sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick: now_ms, echo_us and
//   line_pos. Output channel (out_valid/out_ready) returns one transaction per
//   tick: motor_cmd, the new mode and distance_cm (nonzero only in follow).
//   Config channel (cfg_valid/cfg_ready) writes register cfg_index with
//   cfg_data; cfg_ready is always high, indexes above 7 are dropped. Write
//   only while no tick is in flight.
//   out_valid rises once the tick has passed an input register, one pass of
//   mode logic and the result register. Throughput is one tick per cycle
//   while the receiver keeps up; the mode and start-time registers update as
//   a tick moves into the result register, so the next tick sees them at once.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more tick, then in_ready drops.
//   Reset puts the sequencer in line following with mode start time zero,
//   loads the default thresholds and durations, and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_avoid_sequencer #(
  parameter int TIME_WIDTH = oas_pkg::TIME_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [oas_pkg::NOW_W-1:0]      now_ms,
  input  wire logic [oas_pkg::ECHO_W-1:0]     echo_us,
  input  wire logic [oas_pkg::POS_W-1:0]      line_pos,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [oas_pkg::CMD_W-1:0]           motor_cmd,
  output logic [oas_pkg::MODE_W-1:0]          mode,
  output logic [oas_pkg::DIST_W-1:0]          distance_cm,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [oas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [oas_pkg::CFG_DATA_W-1:0] cfg_data
);

  oas_pkg::cfg_t                cfg;
  logic [oas_pkg::MODE_W-1:0]   cur_mode;
  logic [TIME_WIDTH-1:0]        mode_start;

  logic                         stage_valid;
  logic [oas_pkg::NOW_W-1:0]    now_r;
  logic [oas_pkg::ECHO_W-1:0]   echo_r;
  logic [oas_pkg::POS_W-1:0]    pos_r;

  oas_pkg::step_t               res;
  logic                         advance;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.obstacle_cm       <= oas_pkg::OBSTACLE_CM_RST;
      cfg.stop_ms           <= oas_pkg::STOP_MS_RST;
      cfg.right_turn_ms     <= oas_pkg::RIGHT_TURN_MS_RST;
      cfg.advance_ms        <= oas_pkg::ADVANCE_MS_RST;
      cfg.left_turn_ms      <= oas_pkg::LEFT_TURN_MS_RST;
      cfg.search_timeout_ms <= oas_pkg::SEARCH_MS_RST;
      cfg.line_low          <= oas_pkg::LINE_LOW_RST;
      cfg.line_high         <= oas_pkg::LINE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        oas_pkg::REG_OBSTACLE_CM:
          cfg.obstacle_cm <= cfg_data[oas_pkg::DIST_W-1:0];
        oas_pkg::REG_STOP_MS:
          cfg.stop_ms <= cfg_data[oas_pkg::DUR_W-1:0];
        oas_pkg::REG_RIGHT_TURN_MS:
          cfg.right_turn_ms <= cfg_data[oas_pkg::DUR_W-1:0];
        oas_pkg::REG_ADVANCE_MS:
          cfg.advance_ms <= cfg_data[oas_pkg::DUR_W-1:0];
        oas_pkg::REG_LEFT_TURN_MS:
          cfg.left_turn_ms <= cfg_data[oas_pkg::DUR_W-1:0];
        oas_pkg::REG_SEARCH_TIMEOUT_MS:
          cfg.search_timeout_ms <= cfg_data[oas_pkg::DUR_W-1:0];
        oas_pkg::REG_LINE_LOW:
          cfg.line_low <= cfg_data[oas_pkg::POS_W-1:0];
        oas_pkg::REG_LINE_HIGH:
          cfg.line_high <= cfg_data[oas_pkg::POS_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r  <= now_ms;
      echo_r <= echo_us;
      pos_r  <= line_pos;
    end
  end

  oas_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .cur_mode  (cur_mode),
    .mode_start(mode_start),
    .cfg       (cfg),
    .now_ms    (now_r),
    .echo_us   (echo_r),
    .line_pos  (pos_r),
    .res       (res)
  );

  // Sequencer state advances with the tick that leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode   <= oas_pkg::MODE_FOLLOW;
      mode_start <= '0;
    end else if (advance) begin
      cur_mode <= res.mode;
      if (res.load_start) begin
        mode_start <= TIME_WIDTH'(now_r);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_cmd   <= res.cmd;
      mode        <= res.mode;
      distance_cm <= res.dist_cm;
    end
  end

endmodule

`default_nettype wire
